### rtl/bble_pkg.sv
// Shared types and constants for the bounded byte list engine.
// Holds the request and status codes and the controller/datapath command and status structs.
// No dependencies.
package bble_pkg;

  // default list capacity
  localparam int DEF_CAPACITY = 16;

  // field widths of the stream items
  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 8;
  localparam int INDEX_W  = 4;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SORT   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // memory read address select
  typedef enum logic [2:0] {
    RD_INDEX,
    RD_ZERO,
    RD_ONE,
    RD_I_NEXT,
    RD_I_PREV,
    RD_J_PREV2
  } rd_sel_t;

  // memory write address select
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_W,
    WA_J
  } wa_sel_t;

  // memory write data select
  typedef enum logic [1:0] {
    WD_VALUE,
    WD_RDATA,
    WD_KEY
  } wd_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    cnt_inc;
    logic    cnt_from_w;
    logic    i_set1;
    logic    i_inc;
    logic    w_inc;
    logic    j_from_i;
    logic    j_dec;
    logic    key_load;
    logic    data_load;
    logic    found_set;
    logic    stat_full;
    logic    stat_range;
    logic    out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             idx_ok;
    logic             cnt_zero;
    logic             cnt_le1;
    logic             last;
    logic             match;
    logic             rd_gt_key;
    logic             j_gt1;
    logic             out_free;
  } dp_stat_t;

endpackage

### rtl/bble_dp.sv
// Datapath of the bounded byte list engine: entry memory, count, walk pointers,
// request and result registers, and the output register. Uses bble_pkg.
module bble_dp
  import bble_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  // entry memory
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // list and walk state
  logic [CW-1:0] count;
  logic [CW-1:0] i;
  logic [CW-1:0] w;
  logic [CW-1:0] j;
  logic [CW-1:0] ip1;
  logic [CW-1:0] im1;
  logic [CW-1:0] jm2;

  // request and result registers
  logic [REQ_W-1:0]    req;
  logic [VALUE_W-1:0]  value;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  key;
  logic [VALUE_W-1:0]  data;
  logic                found;
  logic [CW-1:0]       pos;
  logic [STATUS_W-1:0] status;

  assign ip1 = i + CW'(1);
  assign im1 = i - CW'(1);
  assign jm2 = j - CW'(2);

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_INDEX:   rd_addr = AW'(index);
      RD_ZERO:    rd_addr = '0;
      RD_ONE:     rd_addr = AW'(1);
      RD_I_NEXT:  rd_addr = ip1[AW-1:0];
      RD_I_PREV:  rd_addr = im1[AW-1:0];
      RD_J_PREV2: rd_addr = jm2[AW-1:0];
      default:    rd_addr = '0;
    endcase
  end

  // write address and data select
  always_comb begin
    unique case (cmd.wa_sel)
      WA_COUNT: wr_addr = count[AW-1:0];
      WA_W:     wr_addr = w[AW-1:0];
      WA_J:     wr_addr = j[AW-1:0];
      default:  wr_addr = '0;
    endcase
    unique case (cmd.wd_sel)
      WD_VALUE: wr_data = value;
      WD_RDATA: wr_data = rd_data;
      WD_KEY:   wr_data = key;
      default:  wr_data = value;
    endcase
  end

  // memory port, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_from_w) begin
      count <= w;
    end
  end

  // request capture, walk pointers and result fields
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req    <= in_data[REQ_W-1:0];
      value  <= in_data[REQ_W +: VALUE_W];
      index  <= in_data[REQ_W+VALUE_W +: INDEX_W];
      data   <= '0;
      found  <= 1'b0;
      pos    <= '0;
      status <= ST_OK;
      i      <= '0;
      w      <= '0;
    end else begin
      if (cmd.i_set1) begin
        i <= CW'(1);
      end else if (cmd.i_inc) begin
        i <= ip1;
      end
      if (cmd.w_inc) begin
        w <= w + CW'(1);
      end
      if (cmd.j_from_i) begin
        j <= i;
      end else if (cmd.j_dec) begin
        j <= j - CW'(1);
      end
      if (cmd.key_load) begin
        key <= rd_data;
      end
      if (cmd.data_load) begin
        data <= rd_data;
      end
      if (cmd.found_set) begin
        found <= 1'b1;
        pos   <= i;
      end
      if (cmd.stat_full) begin
        status <= ST_FULL;
      end else if (cmd.stat_range) begin
        status <= ST_RANGE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {4'b0000, status, COUNT_W'(count), POS_W'(pos), found, data};
    end
  end

  // status back to the controller
  always_comb begin
    stat.req       = req;
    stat.full      = (count >= CW'(CAPACITY));
    stat.idx_ok    = (CMPW'(index) < CMPW'(count));
    stat.cnt_zero  = (count == '0);
    stat.cnt_le1   = (count <= CW'(1));
    stat.last      = (ip1 >= count);
    stat.match     = (rd_data == value);
    stat.rd_gt_key = ($signed(rd_data) > $signed(key));
    stat.j_gt1     = (j > CW'(1));
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

### rtl/bble_ctrl.sv
// Controller of the bounded byte list engine: sequences each request over the datapath.
// Uses bble_pkg; drives dp_cmd_t and reads dp_stat_t.
module bble_ctrl
  import bble_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_DECODE     = 9'b000000010,
    S_READ       = 9'b000000100,
    S_SCAN       = 9'b000001000,
    S_REM_END    = 9'b000010000,
    S_SORT_KEY   = 9'b000100000,
    S_SORT_CMP   = 9'b001000000,
    S_SORT_PLACE = 9'b010000000,
    S_FINISH     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.wa_sel = WA_COUNT;
    cmd.wd_sel = WD_VALUE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (stat.req) inside
          REQ_APPEND: begin
            if (stat.full) begin
              cmd.stat_full = 1'b1;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = WA_COUNT;
              cmd.wd_sel  = WD_VALUE;
              cmd.cnt_inc = 1'b1;
            end
          end
          REQ_READ: begin
            if (stat.idx_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_INDEX;
              state_next = S_READ;
            end else begin
              cmd.stat_range = 1'b1;
            end
          end
          REQ_REMOVE, REQ_SEARCH: begin
            if (!stat.cnt_zero) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_SCAN;
            end
          end
          REQ_SORT: begin
            if (!stat.cnt_le1) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_ONE;
              cmd.i_set1 = 1'b1;
              state_next = S_SORT_KEY;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_READ: begin
        cmd.data_load = 1'b1;
        state_next    = S_FINISH;
      end
      // one entry per cycle, next read issued alongside
      S_SCAN: begin
        if (stat.req == REQ_SEARCH) begin
          if (stat.match) begin
            cmd.found_set = 1'b1;
            state_next    = S_FINISH;
          end else if (stat.last) begin
            state_next = S_FINISH;
          end else begin
            cmd.i_inc  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I_NEXT;
          end
        end else begin
          if (!stat.match) begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_W;
            cmd.wd_sel = WD_RDATA;
            cmd.w_inc  = 1'b1;
          end
          if (stat.last) begin
            state_next = S_REM_END;
          end else begin
            cmd.i_inc  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I_NEXT;
          end
        end
      end
      S_REM_END: begin
        cmd.cnt_from_w = 1'b1;
        state_next     = S_FINISH;
      end
      // insertion sort: take key, shift larger entries up, place key
      S_SORT_KEY: begin
        cmd.key_load = 1'b1;
        cmd.j_from_i = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_I_PREV;
        state_next   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (stat.rd_gt_key) begin
          cmd.wr_en  = 1'b1;
          cmd.wa_sel = WA_J;
          cmd.wd_sel = WD_RDATA;
          cmd.j_dec  = 1'b1;
          if (stat.j_gt1) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_J_PREV2;
          end else begin
            state_next = S_SORT_PLACE;
          end
        end else begin
          state_next = S_SORT_PLACE;
        end
      end
      S_SORT_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_J;
        cmd.wd_sel = WD_KEY;
        if (stat.last) begin
          state_next = S_FINISH;
        end else begin
          cmd.i_inc  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I_NEXT;
          state_next = S_SORT_KEY;
        end
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/bounded_byte_list_engine.sv
// Bounded byte list engine: ordered list of up to CAPACITY signed bytes.
// Request items enter on the s_axis channel, one result item per request leaves on m_axis.
// Each request appends, reads at an index, removes all equal entries, searches
// for the first match or sorts the list ascending in signed order.
// The walk is bounded by the single read and single write port of the entry memory, one
// entry per cycle when scanning. After accept, each request passes S_DECODE and any walk
// states, then waits in S_FINISH until the output register is free. The next request is
// taken in the cycle after a result is loaded.
// One request is in work at a time; s_axis_tready is high only while the engine is idle.
// A finished result sits in an output register, so the next request is taken while
// it waits; if the receiver keeps m_axis_tready low, the following result holds in the
// controller until that register frees up.
// Reset empties the list at once; entries are not cleared and read only after written.
// Uses bble_pkg, bble_ctrl and bble_dp.
module bounded_byte_list_engine
  import bble_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type[2:0], value[10:3], index[14:11], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // data[7:0], found[8], position[12:9], entry_count[17:13], status[19:18], zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // request sequencer
  bble_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // list storage and result path
  bble_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for bounded_byte_list_engine: drives list requests on s_axis,
// predicts each result with its own copy of the list and compares it on m_axis.
// Depends on bble_pkg and the bounded_byte_list_engine RTL.
module tb;
  import bble_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1120;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 200;

  // request codes the engine leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]          kind;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
  } list_req_t;

  typedef struct {
    logic signed [VALUE_W-1:0] data;
    logic                      found;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        entry_count;
    logic [STATUS_W-1:0]       status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  bounded_byte_list_engine #(.CAPACITY(CAP)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  list_req_t    cur_req;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] shadow_entries[CAP];
  int unsigned               shadow_count = 0;

  int errors = 0;
  int results_checked = 0;
  int op_seen[8];
  int full_seen = 0;
  int range_seen = 0;
  int hits_seen = 0;

  // apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int unsigned w;
    int j;
    logic signed [VALUE_W-1:0] key;
    res.data = '0;
    res.found = 1'b0;
    res.position = '0;
    res.status = ST_OK;
    case (r.kind)
      REQ_APPEND: begin
        if (shadow_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = r.value;
          shadow_count++;
        end
      end
      REQ_READ: begin
        if (r.index < shadow_count) res.data = shadow_entries[r.index];
        else res.status = ST_RANGE;
      end
      REQ_REMOVE: begin
        w = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] != r.value) begin
            shadow_entries[w] = shadow_entries[i];
            w++;
          end
        end
        shadow_count = w;
      end
      REQ_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (!res.found && shadow_entries[i] == r.value) begin
            res.found = 1'b1;
            res.position = POS_W'(i);
          end
        end
      end
      REQ_SORT: begin
        // insertion sort, signed ascending
        for (int i = 1; i < shadow_count; i++) begin
          key = shadow_entries[i];
          j = i;
          while (j > 0 && shadow_entries[j-1] > key) begin
            shadow_entries[j] = shadow_entries[j-1];
            j--;
          end
          shadow_entries[j] = key;
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  task automatic queue_request(logic [REQ_W-1:0] kind, int value, int index);
    list_req_t r;
    r.kind = kind;
    r.value = VALUE_W'(value);
    r.index = INDEX_W'(index);
    pending_reqs.push_back(r);
  endtask

  // request driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_request(cur_req));
        op_seen[cur_req.kind]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_axis_tdata <= {1'b0, cur_req.index, cur_req.value, cur_req.kind};
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // result monitor with its own stall pattern
  logic [15:0] stall_pat = 16'hffff;
  int pat_age = 0;
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata[7:0];
        got.found = m_axis_tdata[8];
        got.position = m_axis_tdata[12:9];
        got.entry_count = m_axis_tdata[17:13];
        got.status = m_axis_tdata[19:18];
        if (expected_results.size() == 0) begin
          $display("[%0t] result item with nothing expected", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got.data !== want.data) report_mismatch("data", got.data, want.data);
          if (got.found !== want.found) report_mismatch("found", got.found, want.found);
          if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_RANGE) range_seen++;
          if (want.found) hits_seen++;
        end
      end
      // reload the pattern now and then; some stretches never stall
      if (pat_age == 63) begin
        pat_age = 0;
        stall_pat = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom) | 16'h0001;
      end else begin
        pat_age++;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      m_axis_tready <= stall_pat[0];
    end
  end

  // watchdog on cycles with work pending but no item moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    automatic int fill_vals[16] = '{-128, 127, 0, -1, 1, 5, -5, 127, -128, 3, 3, -2, 64, -64,
                                    0, 7};
    automatic int value_pool[8] = '{-128, 127, 0, -1, 1, 3, -64, 42};
    int append_pct;
    int pick;
    int value;
    logic [REQ_W-1:0] kind;

    // directed: fill to capacity, then each operation and corner
    foreach (fill_vals[i]) queue_request(REQ_APPEND, fill_vals[i], i);
    queue_request(REQ_APPEND, 9, 0);      // list full
    queue_request(REQ_READ, 0, 15);
    queue_request(REQ_READ, 0, 0);
    queue_request(REQ_SEARCH, 127, 0);
    queue_request(REQ_SEARCH, 100, 15);   // no match
    queue_request(REQ_SORT, 0, 0);
    queue_request(REQ_READ, 0, 15);
    queue_request(REQ_REMOVE, -128, 0);
    queue_request(REQ_READ, 0, 15);       // past the end now
    queue_request(REQ_REMOVE, 100, 0);    // nothing to remove
    queue_request(REQ_SPARE_A, 0, 0);
    queue_request(REQ_SPARE_B, -1, 15);
    queue_request(REQ_SPARE_C, 127, 7);

    // random: append share varies so the list both fills and drains
    append_pct = 40;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 60 == 0) append_pct = $urandom_range(15, 70);
      if ($urandom_range(99) < append_pct) begin
        kind = REQ_APPEND;
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) kind = REQ_READ;
        else if (pick < 65) kind = REQ_SEARCH;
        else if (pick < 85) kind = REQ_REMOVE;
        else kind = REQ_SORT;
      end
      value = ($urandom_range(99) < 60) ? value_pool[$urandom_range(7)]
                                        : $urandom_range(255) - 128;
      queue_request(kind, value, $urandom_range(15));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: append %0d, read %0d, remove %0d, search %0d, sort %0d",
             results_checked, op_seen[REQ_APPEND], op_seen[REQ_READ], op_seen[REQ_REMOVE],
             op_seen[REQ_SEARCH], op_seen[REQ_SORT]);
    $display("unused codes %0d, full appends %0d, out of range reads %0d, search hits %0d",
             op_seen[REQ_SPARE_A] + op_seen[REQ_SPARE_B] + op_seen[REQ_SPARE_C],
             full_seen, range_seen, hits_seen);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
